// ===== hw/rtl/mkp_pkg.sv =====
package mkp_pkg;

  localparam int NUM_BLOCKS       = 16;
  localparam int BLK_W            = 4;
  localparam int PROB_BITS        = 16;
  localparam int WGT_W            = 16;
  localparam int BIU_W            = 5;
  localparam int MAX_PREFETCH_DEF = 4;
  localparam int T1_AW            = 2 * BLK_W;
  localparam int T2_AW            = 3 * BLK_W;
  localparam int T1_DEPTH         = NUM_BLOCKS * NUM_BLOCKS;
  localparam int T2_DEPTH         = NUM_BLOCKS * NUM_BLOCKS * NUM_BLOCKS;
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 16;

  localparam logic [1:0] OP_ACCESS = 2'd0;
  localparam logic [1:0] OP_WR1    = 2'd1;
  localparam logic [1:0] OP_WR2    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THR    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_W1     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_W2     = 3'd4;

  localparam logic [BIU_W-1:0]     BIU_RST = 5'd16;
  localparam logic [PROB_BITS-1:0] THR_RST = 16'd3277;
  localparam logic [WGT_W-1:0]     W1_RST  = 16'd19661;
  localparam logic [WGT_W-1:0]     W2_RST  = 16'd45875;

  typedef struct packed {
    logic                 valid;
    logic [BLK_W-1:0]     blk;
    logic [PROB_BITS-1:0] score;
  } cand_t;

endpackage

// ===== hw/rtl/mkp_in_if.sv =====
interface mkp_in_if
  import mkp_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [1:0]           operation;
  logic [BLK_W-1:0]     block;
  logic [BLK_W-1:0]     from_block;
  logic [BLK_W-1:0]     from_block_earlier;
  logic [PROB_BITS-1:0] probability;

  modport source (output valid, operation, block, from_block, from_block_earlier,
                  probability, input ready);
  modport sink (input valid, operation, block, from_block, from_block_earlier,
                probability, output ready);
endinterface

// ===== hw/rtl/mkp_out_if.sv =====
interface mkp_out_if
  import mkp_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [BLK_W-1:0]     predicted_block;
  logic [PROB_BITS-1:0] confidence;
  logic                 found;
  logic                 last;

  modport source (output valid, predicted_block, confidence, found, last, input ready);
  modport sink (input valid, predicted_block, confidence, found, last, output ready);
endinterface

// ===== hw/rtl/mkp_ram.sv =====
module mkp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/mkp_blend.sv =====
module mkp_blend
  import mkp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  cand_t                in_cand,
  input  logic [PROB_BITS-1:0] s2,
  input  logic                 blend,
  input  logic [WGT_W-1:0]     w1,
  input  logic [WGT_W-1:0]     w2,
  output cand_t                out_cand
);
  localparam int PW = PROB_BITS + WGT_W;

  logic                 v_r;
  logic [BLK_W-1:0]     blk_r;
  logic [PROB_BITS-1:0] s1_r;
  logic [PW-1:0]        p1_r;
  logic [PW-1:0]        p2_r;
  logic                 blend_r;
  logic [PW+1:0]        acc;
  logic [PW+1-PROB_BITS:0] sh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= in_cand.valid;
    end
    blk_r   <= in_cand.blk;
    s1_r    <= in_cand.score;
    p1_r    <= in_cand.score * w1;
    p2_r    <= s2 * w2;
    blend_r <= blend;
  end

  always_comb begin
    acc = {2'b0, p1_r} + {2'b0, p2_r} + ((PW+2)'(1) << (PROB_BITS - 1));
    sh  = acc[PW+1:PROB_BITS];
    out_cand.valid = v_r;
    out_cand.blk   = blk_r;
    if (!blend_r) begin
      out_cand.score = s1_r;
    end else if (sh > (PW+2-PROB_BITS)'({PROB_BITS{1'b1}})) begin
      out_cand.score = {PROB_BITS{1'b1}};
    end else begin
      out_cand.score = sh[PROB_BITS-1:0];
    end
  end
endmodule

// ===== hw/rtl/mkp_topk.sv =====
module mkp_topk
  import mkp_pkg::*;
#(
  parameter int K = MAX_PREFETCH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            clear,
  input  cand_t                           cand,
  input  logic [PROB_BITS-1:0]            thr,
  input  logic [((K>1)?$clog2(K):1)-1:0]  rd_idx,
  output logic [$clog2(K+1)-1:0]          cnt,
  output logic [BLK_W-1:0]                rd_blk,
  output logic [PROB_BITS-1:0]            rd_score
);
  localparam int CW = $clog2(K + 1);

  logic [PROB_BITS-1:0] sc_r [K];
  logic [BLK_W-1:0]     bk_r [K];
  logic [CW-1:0]        cnt_r;
  logic [K-1:0]         gt;
  logic                 ins;

  always_comb begin
    for (int i = 0; i < K; i++) begin
      gt[i] = (CW'(i) >= cnt_r) || (cand.score > sc_r[i]);
    end
    ins = cand.valid && (cand.score > thr) && (|gt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      cnt_r <= '0;
    end else if (ins && cnt_r != CW'(K)) begin
      cnt_r <= cnt_r + CW'(1);
    end
    if (ins) begin
      for (int i = 0; i < K; i++) begin
        if (gt[i]) begin
          if (i == 0 || !gt[(i == 0) ? 0 : i-1]) begin
            sc_r[i] <= cand.score;
            bk_r[i] <= cand.blk;
          end else begin
            sc_r[i] <= sc_r[(i == 0) ? 0 : i-1];
            bk_r[i] <= bk_r[(i == 0) ? 0 : i-1];
          end
        end
      end
    end
  end

  assign cnt      = cnt_r;
  assign rd_blk   = bk_r[rd_idx];
  assign rd_score = sc_r[rd_idx];
endmodule

// ===== hw/rtl/markov_block_prefetch_predictor_top.sv =====
// channel  dir  beat
// in_ch    in   operation, block, from_block, from_block_earlier, probability
// out_ch   out  predicted_block, confidence, found, last
// cfg_*    in   write enable, register index, data; no handshake
//
// an in-range access scans the row of N tracked blocks through the table read
// and blend pipeline, then emits one result per cycle while out_ch is ready
// after reset the tables are cleared one entry a cycle, through every entry,
// with in_ch.ready low; configuration writes are taken throughout
// a stalled out_ch holds the result register, the next access's results wait for it
module markov_block_prefetch_predictor_top
  import mkp_pkg::*;
#(
  parameter int MAX_PREFETCH = MAX_PREFETCH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  mkp_in_if.sink                in_ch,
  mkp_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);
  localparam int CW = $clog2(MAX_PREFETCH + 1);
  localparam int IW = (MAX_PREFETCH > 1) ? $clog2(MAX_PREFETCH) : 1;

  typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_SCAN, ST_DRAIN, ST_EMIT} state_t;

  state_t               state_r;
  logic [T2_AW-1:0]     clr_r;
  logic [BIU_W-1:0]     biu_r;
  logic                 mode_r;
  logic [PROB_BITS-1:0] thr_r;
  logic [WGT_W-1:0]     w1_r;
  logic [WGT_W-1:0]     w2_r;
  logic [BLK_W-1:0]     latest_r;
  logic [BLK_W-1:0]     earlier_r;
  logic [1:0]           hc_r;
  logic                 blend_r;
  logic [BLK_W:0]       j_r;
  logic                 rv_r;
  logic [BLK_W-1:0]     rj_r;
  logic                 drn_r;
  logic [CW-1:0]        em_r;
  logic                 out_valid_r;
  logic [BLK_W-1:0]     out_blk_r;
  logic [PROB_BITS-1:0] out_conf_r;
  logic                 out_found_r;
  logic                 out_last_r;

  logic [BIU_W-1:0]     n_eff;
  logic                 acc;
  logic                 in_range;
  logic                 issue_ok;
  logic                 we1;
  logic                 we2;
  logic [T1_AW-1:0]     wa1;
  logic [T2_AW-1:0]     wa2;
  logic [PROB_BITS-1:0] wd;
  logic [PROB_BITS-1:0] s1;
  logic [PROB_BITS-1:0] s2;
  cand_t                rd_cand;
  cand_t                sc_cand;
  logic [CW-1:0]        cnt;
  logic [BLK_W-1:0]     tk_blk;
  logic [PROB_BITS-1:0] tk_score;
  logic                 out_free;

  assign n_eff    = (biu_r > BIU_W'(NUM_BLOCKS)) ? BIU_W'(NUM_BLOCKS) : biu_r;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign acc      = in_ch.valid && in_ch.ready;
  assign in_range = {1'b0, in_ch.block} < n_eff;
  assign issue_ok = (j_r != {1'b0, latest_r});
  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    if (state_r == ST_CLEAR) begin
      we1 = 1'b1;
      we2 = 1'b1;
      wa1 = clr_r[T1_AW-1:0];
      wa2 = clr_r;
      wd  = '0;
    end else begin
      we1 = acc && (in_ch.operation == OP_WR1);
      we2 = acc && (in_ch.operation == OP_WR2);
      wa1 = {in_ch.from_block, in_ch.block};
      wa2 = {in_ch.from_block_earlier, in_ch.from_block, in_ch.block};
      wd  = in_ch.probability;
    end
  end

  mkp_ram #(.WIDTH(PROB_BITS), .DEPTH(T1_DEPTH)) u_t1 (
    .clk   (clk),
    .we    (we1),
    .waddr (wa1),
    .wdata (wd),
    .raddr ({latest_r, j_r[BLK_W-1:0]}),
    .rdata (s1)
  );

  mkp_ram #(.WIDTH(PROB_BITS), .DEPTH(T2_DEPTH)) u_t2 (
    .clk   (clk),
    .we    (we2),
    .waddr (wa2),
    .wdata (wd),
    .raddr ({earlier_r, latest_r, j_r[BLK_W-1:0]}),
    .rdata (s2)
  );

  always_comb begin
    rd_cand.valid = rv_r;
    rd_cand.blk   = rj_r;
    rd_cand.score = s1;
  end

  mkp_blend u_blend (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_cand  (rd_cand),
    .s2       (s2),
    .blend    (blend_r),
    .w1       (w1_r),
    .w2       (w2_r),
    .out_cand (sc_cand)
  );

  mkp_topk #(.K(MAX_PREFETCH)) u_topk (
    .clk      (clk),
    .rst_n    (rst_n),
    .clear    (acc && (in_ch.operation == OP_ACCESS)),
    .cand     (sc_cand),
    .thr      (thr_r),
    .rd_idx   (em_r[IW-1:0]),
    .cnt      (cnt),
    .rd_blk   (tk_blk),
    .rd_score (tk_score)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      biu_r  <= BIU_RST;
      mode_r <= 1'b0;
      thr_r  <= THR_RST;
      w1_r   <= W1_RST;
      w2_r   <= W2_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BLOCKS: biu_r  <= cfg_data[BIU_W-1:0];
        CFG_MODE:   mode_r <= cfg_data[0];
        CFG_THR:    thr_r  <= cfg_data[PROB_BITS-1:0];
        CFG_W1:     w1_r   <= cfg_data[WGT_W-1:0];
        CFG_W2:     w2_r   <= cfg_data[WGT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      latest_r    <= '0;
      earlier_r   <= '0;
      hc_r        <= '0;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
      j_r         <= '0;
      drn_r       <= 1'b0;
      em_r        <= '0;
      blend_r     <= 1'b0;
    end else begin
      rv_r <= (state_r == ST_SCAN) && issue_ok;
      rj_r <= j_r[BLK_W-1:0];
      if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + T2_AW'(1);
          if (clr_r == {T2_AW{1'b1}}) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (acc && in_ch.operation == OP_ACCESS) begin
            em_r <= '0;
            if (in_range) begin
              earlier_r <= latest_r;
              latest_r  <= in_ch.block;
              if (hc_r != 2'd2) begin
                hc_r <= hc_r + 2'd1;
              end
              blend_r <= mode_r && (hc_r != 2'd0);
              j_r     <= '0;
              state_r <= ST_SCAN;
            end else begin
              state_r <= ST_EMIT;
            end
          end
        end
        ST_SCAN: begin
          j_r <= j_r + (BLK_W+1)'(1);
          if (j_r == (BLK_W+1)'(n_eff - BIU_W'(1))) begin
            drn_r   <= 1'b1;
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          drn_r <= 1'b0;
          if (!drn_r) begin
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            if (cnt == '0) begin
              out_blk_r   <= '0;
              out_conf_r  <= '0;
              out_found_r <= 1'b0;
              out_last_r  <= 1'b1;
              state_r     <= ST_IDLE;
            end else begin
              out_blk_r   <= tk_blk;
              out_conf_r  <= tk_score;
              out_found_r <= 1'b1;
              out_last_r  <= (em_r + CW'(1) == cnt);
              em_r        <= em_r + CW'(1);
              if (em_r + CW'(1) == cnt) begin
                state_r <= ST_IDLE;
              end
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.predicted_block = out_blk_r;
  assign out_ch.confidence      = out_conf_r;
  assign out_ch.found           = out_found_r;
  assign out_ch.last            = out_last_r;

  a_notfound_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.found |-> out_ch.last)
    else $error("not-found beat without last");

  a_above_thr: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.found |-> out_ch.confidence > thr_r)
    else $error("candidate at or below threshold");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |=> !in_ch.ready)
    else $error("input taken during scan");
endmodule

// ===== bench/tb_markov_block_prefetch_predictor_top.sv =====
`timescale 1ns / 1ps

module tb_markov_block_prefetch_predictor_top;
  import mkp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic [1:0] OP_NONE = 2'd3;

  typedef struct {
    logic [1:0]           op;
    logic [BLK_W-1:0]     blk;
    logic [BLK_W-1:0]     from;
    logic [BLK_W-1:0]     from_earlier;
    logic [PROB_BITS-1:0] prob;
  } prefetch_req_t;

  typedef struct packed {
    logic [BLK_W-1:0]     blk;
    logic [PROB_BITS-1:0] conf;
    logic                 found;
    logic                 last;
  } prefetch_hint_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  mkp_in_if  in_ch ();
  mkp_out_if out_ch ();

  markov_block_prefetch_predictor_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow state of the predictor
  logic [PROB_BITS-1:0] order1_prob [T1_DEPTH];
  logic [PROB_BITS-1:0] order2_prob [T2_DEPTH];
  logic [BLK_W-1:0]     hist_latest;
  logic [BLK_W-1:0]     hist_earlier;
  int                   hist_depth;
  logic [BIU_W-1:0]     blocks_in_use;
  logic                 blend_mode;
  logic [PROB_BITS-1:0] threshold;
  logic [WGT_W-1:0]     weight1;
  logic [WGT_W-1:0]     weight2;

  prefetch_req_t  req_pending [$];
  prefetch_hint_t hint_expected [$];
  int mismatches = 0;
  int cycles = 0;

  function automatic prefetch_hint_t no_hint();
    prefetch_hint_t h;
    h.blk = '0;
    h.conf = '0;
    h.found = 1'b0;
    h.last = 1'b1;
    return h;
  endfunction

  task automatic predict_hints(input prefetch_req_t r);
    int n;
    int best;
    int best_j;
    int emitted;
    logic [63:0] acc;
    logic [PROB_BITS-1:0] s1;
    logic [PROB_BITS-1:0] s2;
    int score [NUM_BLOCKS];
    bit taken [NUM_BLOCKS];
    prefetch_hint_t h;
    case (r.op)
      OP_WR1: order1_prob[{r.from, r.blk}] = r.prob;
      OP_WR2: order2_prob[{r.from_earlier, r.from, r.blk}] = r.prob;
      OP_ACCESS: begin
        n = (blocks_in_use < NUM_BLOCKS) ? int'(blocks_in_use) : NUM_BLOCKS;
        if (int'(r.blk) >= n) begin
          hint_expected.push_back(no_hint());
        end else begin
          hist_earlier = hist_latest;
          hist_latest = r.blk;
          if (hist_depth < 2) hist_depth++;
          for (int j = 0; j < NUM_BLOCKS; j++) begin
            score[j] = 0;
            taken[j] = (j >= n) || (j == int'(r.blk));
            if (!taken[j]) begin
              s1 = order1_prob[{hist_latest, 4'(j)}];
              if (blend_mode && hist_depth >= 2) begin
                s2 = order2_prob[{hist_earlier, hist_latest, 4'(j)}];
                acc = 64'(s1) * weight1 + 64'(s2) * weight2 + 64'd32768;
                acc = acc >> 16;
                score[j] = (acc > 64'd65535) ? 65535 : int'(acc);
              end else begin
                score[j] = s1;
              end
            end
          end
          emitted = 0;
          for (int slot = 0; slot < MAX_PREFETCH_DEF; slot++) begin
            best = threshold;
            best_j = -1;
            for (int j = 0; j < NUM_BLOCKS; j++) begin
              if (!taken[j] && score[j] > best) begin
                best = score[j];
                best_j = j;
              end
            end
            if (best_j >= 0) begin
              taken[best_j] = 1'b1;
              h.blk = best_j;
              h.conf = best;
              h.found = 1'b1;
              h.last = 1'b0;
              hint_expected.push_back(h);
              emitted++;
            end
          end
          if (emitted == 0) hint_expected.push_back(no_hint());
          else hint_expected[hint_expected.size()-1].last = 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  // request driver
  prefetch_req_t cur_req;
  int  send_gap = 0;
  bit  send_burst = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) predict_hints(cur_req);
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (req_pending.size() > 0) begin
          cur_req = req_pending.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.operation <= cur_req.op;
          in_ch.block <= cur_req.blk;
          in_ch.from_block <= cur_req.from;
          in_ch.from_block_earlier <= cur_req.from_earlier;
          in_ch.probability <= cur_req.prob;
          if ($urandom_range(0, 15) == 0) send_burst = !send_burst;
          send_gap = send_burst ? 0 : $urandom_range(0, 5);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // hint monitor
  int  recv_stall = 0;
  bit  recv_burst = 0;
  prefetch_hint_t got_hint;
  prefetch_hint_t exp_hint;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got_hint = {out_ch.predicted_block, out_ch.confidence, out_ch.found, out_ch.last};
        if (hint_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected beat %p", got_hint);
        end else begin
          exp_hint = hint_expected.pop_front();
          if (got_hint !== exp_hint) begin
            mismatches++;
            if (mismatches <= 10) $display("beat mismatch exp %p got %p", exp_hint, got_hint);
          end
        end
        if ($urandom_range(0, 15) == 0) recv_burst = !recv_burst;
        recv_stall = recv_burst ? 0 : $urandom_range(0, 5);
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_BLOCKS: blocks_in_use = val[BIU_W-1:0];
      CFG_MODE:   blend_mode = val[0];
      CFG_THR:    threshold = val;
      CFG_W1:     weight1 = val;
      CFG_W2:     weight2 = val;
      default: ;
    endcase
  endtask

  task automatic configure(input int biu, input int mode, input int thr, input int w1,
                           input int w2);
    set_reg(CFG_BLOCKS, biu);
    set_reg(CFG_MODE, mode);
    set_reg(CFG_THR, thr);
    set_reg(CFG_W1, w1);
    set_reg(CFG_W2, w2);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_req(input logic [1:0] op, input int blk, input int from,
                           input int from_e, input int prob);
    prefetch_req_t r;
    r.op = op;
    r.blk = blk;
    r.from = from;
    r.from_earlier = from_e;
    r.prob = prob;
    req_pending.push_back(r);
  endtask

  // checked away from the rising edge so that driver and monitor updates have settled
  task automatic drain();
    do begin
      @(negedge clk);
    end while (req_pending.size() != 0 || in_ch.valid || hint_expected.size() != 0);
    repeat (40) @(posedge clk);
  endtask

  // mostly a small hot set of blocks so that rows and history pairs get reused
  task automatic queue_random(input int count);
    int pick;
    int span;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      span = ($urandom_range(0, 1) == 1) ? 3 : 15;
      if (pick < 40)
        queue_req(OP_ACCESS, $urandom_range(0, span), 0, 0, $urandom);
      else if (pick < 68)
        queue_req(OP_WR1, $urandom_range(0, span), $urandom_range(0, span), $urandom,
                  $urandom);
      else if (pick < 95)
        queue_req(OP_WR2, $urandom_range(0, span), $urandom_range(0, span),
                  $urandom_range(0, span), $urandom);
      else
        queue_req(($urandom_range(0, 1) == 1) ? OP_NONE : OP_ACCESS, $urandom_range(0, 15),
                  $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.operation = OP_ACCESS;
    in_ch.block = '0;
    in_ch.from_block = '0;
    in_ch.from_block_earlier = '0;
    in_ch.probability = '0;
    out_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_BLOCKS;
    cfg_data = '0;
    for (int i = 0; i < T1_DEPTH; i++) order1_prob[i] = '0;
    for (int i = 0; i < T2_DEPTH; i++) order2_prob[i] = '0;
    hist_latest = '0;
    hist_earlier = '0;
    hist_depth = 0;
    blocks_in_use = BIU_RST;
    blend_mode = 1'b0;
    threshold = THR_RST;
    weight1 = W1_RST;
    weight2 = W2_RST;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty tables, threshold edges, ties, an order 2 write, ignored code
    queue_req(OP_ACCESS, 0, 0, 0, 0);
    queue_req(OP_WR1, 1, 2, 0, 16'hFFFF);
    queue_req(OP_WR1, 3, 2, 0, 3277);
    queue_req(OP_WR1, 4, 2, 0, 3278);
    queue_req(OP_WR1, 5, 2, 0, 3278);
    queue_req(OP_WR1, 15, 2, 0, 16'h8000);
    queue_req(OP_WR1, 6, 2, 0, 50000);
    queue_req(OP_WR1, 2, 2, 0, 60000);
    queue_req(OP_ACCESS, 2, 0, 0, 0);
    queue_req(OP_WR2, 7, 2, 15, 16'hFFFF);
    queue_req(OP_WR1, 0, 15, 15, 0);
    queue_req(OP_ACCESS, 15, 0, 0, 0);
    queue_req(OP_NONE, 15, 15, 15, 16'hFFFF);
    queue_req(OP_ACCESS, 2, 15, 15, 16'hFFFF);
    queue_random(15);
    drain();

    configure(16, 1, 3277, 19661, 45875);
    queue_req(OP_WR2, 1, 2, 15, 16'hFFFF);
    queue_req(OP_WR2, 9, 2, 15, 40000);
    queue_req(OP_ACCESS, 15, 0, 0, 0);
    queue_req(OP_ACCESS, 2, 0, 0, 0);
    queue_random(15);
    drain();

    configure(16, 1, 0, 65535, 65535);
    queue_req(OP_ACCESS, 15, 0, 0, 0);
    queue_req(OP_ACCESS, 2, 0, 0, 0);
    queue_random(15);
    drain();

    configure(1, 1, 65535, 0, 0);
    queue_req(OP_ACCESS, 0, 0, 0, 0);
    queue_req(OP_ACCESS, 1, 0, 0, 0);
    queue_random(8);
    drain();

    configure(5, 0, 1000, 32768, 100);
    queue_random(12);
    drain();

    configure(16, 1, 3277, 19661, 45875);
    queue_random(13);
    drain();

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/mkp_pkg.sv
hw/rtl/mkp_in_if.sv
hw/rtl/mkp_out_if.sv
hw/rtl/mkp_ram.sv
hw/rtl/mkp_blend.sv
hw/rtl/mkp_topk.sv
hw/rtl/markov_block_prefetch_predictor_top.sv
bench/tb_markov_block_prefetch_predictor_top.sv
